/* rtl/slcd_pkg.sv */
// slcd_pkg: shared types and codes for the sync/length/checksum deframer
// no dependencies; imported by slcd_cfg_regs, slcd_parser and the top level
package slcd_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] REG_SYNC_VALUE = 2'd0;
    localparam logic [1:0] REG_MIN_LENGTH = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH = 2'd2;

    // register reset values
    localparam logic [7:0] SYNC_RESET    = 8'hAA;
    localparam logic [7:0] MIN_LEN_RESET = 8'd2;
    localparam logic [7:0] MAX_LEN_RESET = 8'd250;

    // parser phases
    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_SYNC2 = 2'd1;
    localparam logic [1:0] PH_LEN   = 2'd2;
    localparam logic [1:0] PH_BODY  = 2'd3;

    // classification codes of a result item
    localparam logic [2:0] K_NOISE    = 3'd0;
    localparam logic [2:0] K_SYNC1    = 3'd1;
    localparam logic [2:0] K_SYNC2    = 3'd2;
    localparam logic [2:0] K_MISMATCH = 3'd3;
    localparam logic [2:0] K_LEN_OK   = 3'd4;
    localparam logic [2:0] K_LEN_BAD  = 3'd5;
    localparam logic [2:0] K_BODY     = 3'd6;
    localparam logic [2:0] K_END      = 3'd7;

    // current register contents
    typedef struct packed {
        logic [7:0] sync_value;
        logic [7:0] min_length;
        logic [7:0] max_length;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic [7:0] byte_out;
        logic [2:0] kind;
        logic       frame_good;
        logic [7:0] body_index;
        logic [7:0] frame_length;
    } t_result;

endpackage

/* rtl/sync_length_checksum_deframer_unit.sv */
// sync_length_checksum_deframer_unit: top level, input and result registers
// depends on slcd_pkg, slcd_cfg_regs and slcd_parser
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+------------------------------------
//  in       | sink      | i_in_valid / o_in_stall      | i_byte_in
//  out      | source    | o_out_valid / i_out_stall    | o_byte_out, o_kind, o_frame_good,
//           |           |                              | o_body_index, o_frame_length
//  cfg      | sink      | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the output does not stall; an accepted byte passes
// through the input register, then classify and checksum add into the result register
// reset is synchronous, active low, and brings the configuration registers to their defaults
// and the parser to hunting for the first sync byte
// a stall on the output holds the result register and backs up into the input
// register, which raises o_in_stall only when it holds an item that cannot move
module sync_length_checksum_deframer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_byte_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_byte_out,
    output logic [2:0] o_kind,
    output logic       o_frame_good,
    output logic [7:0] o_body_index,
    output logic [7:0] o_frame_length,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import slcd_pkg::*;

    t_cfg       cfg;
    t_result    result;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       advance;
    logic       in_take;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    slcd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // pipeline flow control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_byte_in;
        end
    end

    // frame parser
    slcd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_result  (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_out     = r_out.byte_out;
    assign o_kind         = r_out.kind;
    assign o_frame_good   = r_out.frame_good;
    assign o_body_index   = r_out.body_index;
    assign o_frame_length = r_out.frame_length;

endmodule

/* rtl/slcd_cfg_regs.sv */
// slcd_cfg_regs: sync value and length limit registers
// depends on slcd_pkg
module slcd_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    output slcd_pkg::t_cfg     o_cfg
);
    import slcd_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_value <= SYNC_RESET;
            r_cfg.min_length <= MIN_LEN_RESET;
            r_cfg.max_length <= MAX_LEN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SYNC_VALUE: r_cfg.sync_value <= i_cfg_data;
                REG_MIN_LENGTH: r_cfg.min_length <= i_cfg_data;
                REG_MAX_LENGTH: r_cfg.max_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/slcd_parser.sv */
// slcd_parser: frame state machine, running checksum and byte classification
// depends on slcd_pkg
module slcd_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  slcd_pkg::t_cfg      i_cfg,
    input  logic                i_advance,
    input  logic [7:0]          i_byte,
    output slcd_pkg::t_result   o_result
);
    import slcd_pkg::*;

    logic [1:0] r_phase;
    logic [7:0] r_sum;
    logic [8:0] r_count;
    logic [7:0] r_len;

    logic [1:0] n_phase;
    logic [7:0] n_sum;
    logic [8:0] n_count;
    logic [7:0] n_len;

    logic       sync_hit;
    logic       len_ok;
    logic [7:0] body_sum;
    logic [8:0] body_next;
    logic       body_last;

    assign sync_hit  = (i_byte == i_cfg.sync_value);
    assign len_ok    = (i_byte >= i_cfg.min_length) && (i_byte <= i_cfg.max_length);
    assign body_sum  = r_sum + i_byte;
    assign body_next = r_count + 9'd1;
    assign body_last = (body_next == ({1'b0, r_len} + 9'd1));

    // next state and classification of the byte in the input register
    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_count = r_count;
        n_len   = r_len;
        o_result.byte_out     = i_byte;
        o_result.kind         = K_NOISE;
        o_result.frame_good   = 1'b0;
        o_result.body_index   = 8'd0;
        o_result.frame_length = 8'd0;
        case (r_phase)
            PH_HUNT: begin
                if (sync_hit) begin
                    o_result.kind = K_SYNC1;
                    n_phase       = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (sync_hit) begin
                    o_result.kind = K_SYNC2;
                    n_phase       = PH_LEN;
                end else begin
                    o_result.kind = K_MISMATCH;
                    n_phase       = PH_HUNT;
                end
            end
            PH_LEN: begin
                o_result.frame_length = i_byte;
                if (len_ok) begin
                    o_result.kind = K_LEN_OK;
                    n_len         = i_byte;
                    n_sum         = 8'd0;
                    n_count       = 9'd0;
                    n_phase       = PH_BODY;
                end else begin
                    o_result.kind = K_LEN_BAD;
                    n_phase       = PH_HUNT;
                end
            end
            PH_BODY: begin
                n_sum                 = body_sum;
                n_count               = body_next;
                o_result.body_index   = r_count[7:0];
                o_result.frame_length = r_len;
                if (body_last) begin
                    o_result.kind       = K_END;
                    o_result.frame_good = (body_sum == 8'd0);
                    n_phase             = PH_HUNT;
                end else begin
                    o_result.kind = K_BODY;
                end
            end
            default: n_phase = PH_HUNT;
        endcase
    end

    // state moves only when the item passes to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_sum   <= 8'd0;
            r_count <= 9'd0;
            r_len   <= 8'd0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_count <= n_count;
            r_len   <= n_len;
        end
    end

endmodule
